FILE: sv/rcfd_pkg.sv
// rcfd_pkg: shared types, codes and sizes for the remote control frame decoder
// no dependencies; imported by every module of the decoder
`timescale 1ns / 1ps

package rcfd_pkg;

  // receive buffer sizing
  localparam int BUFFER_BYTES = 36;
  localparam int FRAME_LEN    = 18;
  localparam int COUNT_W      = $clog2(BUFFER_BYTES + 1);

  // field widths
  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int OFFSET_W = 11;
  localparam int DBAND_W  = 10;
  localparam int LIMIT_W  = 16;
  localparam int STICK_W  = 12;
  localparam int WORD_W   = 16;
  localparam int SWITCH_W = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // result payload packing
  localparam int OUT_BITS = 4 * STICK_W + 6 * WORD_W + SWITCH_W;
  localparam int TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_BYTE = 2'd0;
  localparam logic [OP_W-1:0] OP_IDLE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  // event status codes
  localparam logic [STATUS_W-1:0] ST_STORED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DECODED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALIVE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OFFLINE  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DBAND  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd2;

  // configuration reset values
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 11'd1024;
  localparam logic [DBAND_W-1:0]  DBAND_RST  = 10'd20;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 16'd50;

  // stored frame bytes, entry 0 in the low byte
  typedef logic [FRAME_LEN-1:0][BYTE_W-1:0] frame_t;

  // per-transaction control strobes
  typedef struct packed {
    logic store_byte;
    logic frame_end;
    logic tick;
  } step_t;

  // held decoded values (sticks, wheel and mouse are two's complement)
  typedef struct packed {
    logic [WORD_W-1:0]   keys;
    logic [WORD_W-1:0]   buttons;
    logic [WORD_W-1:0]   mouse_z;
    logic [WORD_W-1:0]   mouse_y;
    logic [WORD_W-1:0]   mouse_x;
    logic [SWITCH_W-1:0] switches;
    logic [WORD_W-1:0]   wheel;
    logic [STICK_W-1:0]  stick3;
    logic [STICK_W-1:0]  stick2;
    logic [STICK_W-1:0]  stick1;
    logic [STICK_W-1:0]  stick0;
  } decoded_t;

endpackage

FILE: sv/rcfd_frame_buffer.sv
// rcfd_frame_buffer: byte store for one frame and the saturating byte counter
// depends on rcfd_pkg
`timescale 1ns / 1ps

module rcfd_frame_buffer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rcfd_pkg::step_t            step_i,
  input  logic [rcfd_pkg::BYTE_W-1:0] byte_i,
  output rcfd_pkg::frame_t           frame_o,
  output logic                       frame_ok_o
);
  import rcfd_pkg::*;

  frame_t             store_q;
  logic [COUNT_W-1:0] count_q, count_d;

  // write the byte at the current count, only inside the frame length
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (step_i.store_byte && (count_q == COUNT_W'(i))) begin
        store_q[i] <= byte_i;
      end
    end
  end

  // count saturates at the buffer size, cleared at end of frame
  always_comb begin
    count_d = count_q;
    if (step_i.frame_end) begin
      count_d = '0;
    end else if (step_i.store_byte && (count_q < COUNT_W'(BUFFER_BYTES))) begin
      count_d = count_q + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign frame_o    = store_q;
  assign frame_ok_o = (count_q == COUNT_W'(FRAME_LEN));

endmodule

FILE: sv/rcfd_frame_unpack.sv
// rcfd_frame_unpack: bit unpacking of a stored frame, offset and stick deadband
// depends on rcfd_pkg; purely combinational
`timescale 1ns / 1ps

module rcfd_frame_unpack (
  input  rcfd_pkg::frame_t              frame_i,
  input  logic [rcfd_pkg::OFFSET_W-1:0] offset_i,
  input  logic [rcfd_pkg::DBAND_W-1:0]  dband_i,
  output rcfd_pkg::decoded_t            decoded_o
);
  import rcfd_pkg::*;

  localparam int RAW_W = 11;
  localparam int DIFF_W = 13;

  logic [RAW_W-1:0]   raw [4];
  logic [STICK_W-1:0] stick [4];

  // 11-bit stick fields straddle byte borders
  assign raw[0] = {frame_i[1][2:0], frame_i[0]};
  assign raw[1] = {frame_i[2][5:0], frame_i[1][7:3]};
  assign raw[2] = {frame_i[4][0],   frame_i[3], frame_i[2][7:6]};
  assign raw[3] = {frame_i[5][3:0], frame_i[4][7:1]};

  // subtract centre, zero anything strictly inside the deadband
  always_comb begin
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] band;
    for (int i = 0; i < 4; i++) begin
      diff = $signed({2'b00, raw[i]}) - $signed({2'b00, offset_i});
      band = $signed({3'b000, dband_i});
      if ((diff > -band) && (diff < band)) begin
        stick[i] = '0;
      end else begin
        stick[i] = diff[STICK_W-1:0];
      end
    end
  end

  always_comb begin
    decoded_o          = '0;
    decoded_o.stick0   = stick[0];
    decoded_o.stick1   = stick[1];
    decoded_o.stick2   = stick[2];
    decoded_o.stick3   = stick[3];
    // wheel wraps in 16 bits
    decoded_o.wheel    = {frame_i[17], frame_i[16]} - {5'b00000, offset_i};
    decoded_o.switches = frame_i[5][7:4];
    decoded_o.mouse_x  = {frame_i[7], frame_i[6]};
    decoded_o.mouse_y  = {frame_i[9], frame_i[8]};
    decoded_o.mouse_z  = {frame_i[11], frame_i[10]};
    decoded_o.buttons  = {frame_i[13], frame_i[12]};
    decoded_o.keys     = {frame_i[15], frame_i[14]};
  end

endmodule

FILE: sv/rcfd_link_watch.sv
// rcfd_link_watch: heartbeat tick counter with saturation and offline flag
// depends on rcfd_pkg
`timescale 1ns / 1ps

module rcfd_link_watch (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rcfd_pkg::step_t              step_i,
  input  logic [rcfd_pkg::LIMIT_W-1:0] limit_i,
  output logic                         offline_d_o
);
  import rcfd_pkg::*;

  logic [LIMIT_W-1:0] count_q, count_d;
  logic               flag_q, flag_d;
  logic [LIMIT_W:0]   count_inc;

  assign count_inc = {1'b0, count_q} + (LIMIT_W + 1)'(1);

  // idle clears, a tick past the limit pins the count and raises the flag
  always_comb begin
    count_d = count_q;
    flag_d  = flag_q;
    if (step_i.frame_end) begin
      count_d = '0;
      flag_d  = 1'b0;
    end else if (step_i.tick) begin
      if (count_inc > {1'b0, limit_i}) begin
        count_d = limit_i;
        flag_d  = 1'b1;
      end else begin
        count_d = count_inc[LIMIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      flag_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      flag_q  <= flag_d;
    end
  end

  assign offline_d_o = flag_d;

endmodule

FILE: sv/remote_control_frame_decoder_core.sv
// remote_control_frame_decoder_core: top level of the remote control frame decoder
// a result passes the input register, then the status register, which is loaded
// together with the held decoded values
// throughput: one transaction per cycle while the result side does not stall; an unused operation code gives no result
// reset (async, active low): config registers to defaults, counters, flags and held
// values to zero; the frame byte store is not cleared and needs no clearing pass
`timescale 1ns / 1ps

module remote_control_frame_decoder_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [rcfd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rcfd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [rcfd_pkg::BYTE_W-1:0]    s_axis_tdata,  // data_byte
  input  logic [rcfd_pkg::OP_W-1:0]      s_axis_tuser,  // operation
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // stick_ch0, stick_ch1, stick_ch2, stick_ch3, wheel_ch4, switch_pair,
  // mouse_x, mouse_y, mouse_z, mouse_buttons, key_mask, zero fill
  output logic [rcfd_pkg::TDATA_W-1:0]   m_axis_tdata,
  output logic [rcfd_pkg::STATUS_W-1:0]  m_axis_tuser   // event_status
);
  import rcfd_pkg::*;

  logic [OFFSET_W-1:0] offset_q;
  logic [DBAND_W-1:0]  dband_q;
  logic [LIMIT_W-1:0]  limit_q;

  logic                s1_valid_q;
  logic [OP_W-1:0]     s1_op_q;
  logic [BYTE_W-1:0]   s1_byte_q;

  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q, out_status_d;

  decoded_t            held_q, decoded;
  frame_t              frame;
  logic                frame_ok;
  logic                offline_d;
  logic                advance;
  logic                emit;
  step_t               step;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OFFSET_RST;
      dband_q  <= DBAND_RST;
      limit_q  <= LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_OFFSET: offset_q <= cfg_wdata_i[OFFSET_W-1:0];
        CFG_DBAND:  dband_q  <= cfg_wdata_i[DBAND_W-1:0];
        CFG_LIMIT:  limit_q  <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1 moves on when the result slot frees up; unused codes just drop
  assign advance = s1_valid_q && (!out_valid_q || m_axis_tready || (s1_op_q == OP_NONE));
  assign emit    = advance && (s1_op_q != OP_NONE);
  assign s_axis_tready = !s1_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_op_q   <= s_axis_tuser;
      s1_byte_q <= s_axis_tdata;
    end
  end

  assign step.store_byte = advance && (s1_op_q == OP_BYTE);
  assign step.frame_end  = advance && (s1_op_q == OP_IDLE);
  assign step.tick       = advance && (s1_op_q == OP_TICK);

  rcfd_frame_buffer u_buffer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .byte_i     (s1_byte_q),
    .frame_o    (frame),
    .frame_ok_o (frame_ok)
  );

  rcfd_frame_unpack u_unpack (
    .frame_i   (frame),
    .offset_i  (offset_q),
    .dband_i   (dband_q),
    .decoded_o (decoded)
  );

  rcfd_link_watch u_watch (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .limit_i     (limit_q),
    .offline_d_o (offline_d)
  );

  // status of the transaction being processed
  always_comb begin
    case (s1_op_q)
      OP_BYTE: out_status_d = ST_STORED;
      OP_IDLE: out_status_d = frame_ok ? ST_DECODED : ST_REJECTED;
      OP_TICK: out_status_d = offline_d ? ST_OFFLINE : ST_ALIVE;
      default: out_status_d = ST_STORED;
    endcase
  end

  // held decoded values, replaced only by a good frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (step.frame_end && frame_ok) begin
      held_q <= decoded;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= out_status_d;
    end
  end

  // held values only change when a result is loaded, so they drive tdata directly
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{(TDATA_W - OUT_BITS){1'b0}}, held_q};

endmodule

FILE: sv/rcfd_checker.sv
// rcfd_checker: port-level assertions for the remote control frame decoder
// depends on rcfd_pkg; bound to remote_control_frame_decoder_core below
`timescale 1ns / 1ps

module rcfd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rcfd_pkg::TDATA_W-1:0]   m_axis_tdata,
  input logic [rcfd_pkg::STATUS_W-1:0]  m_axis_tuser
);
  import rcfd_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

  // a result appearing from empty follows an accepted input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a matching input transaction");

  // held values only move with a decoded frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != ST_DECODED) &&
     $past(m_axis_tvalid && m_axis_tready)) |-> $stable(m_axis_tdata))
    else $error("held values changed without a decoded frame");

  // status code in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= ST_OFFLINE))
    else $error("illegal event status");

endmodule

bind remote_control_frame_decoder_core rcfd_checker u_rcfd_checker (.*);

FILE: test/tb_top.sv
// tb_top: self-checking testbench for remote_control_frame_decoder_core
// predicts every report from its own copy of the decoder state and checks each one
// depends on rcfd_pkg and remote_control_frame_decoder_core only
`timescale 1ns / 1ps

module tb_top;

  import rcfd_pkg::*;

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 11;
  localparam int ITEM_TARGET    = 1300;
  localparam int SETTLE_CYCLES  = 6;
  localparam int HOLD_CYCLES    = 200;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int STICK_RAW_MAX  = (1 << OFFSET_W) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [LIMIT_W-1:0]   LIMIT_MAX  = 16'hFFFF;
  localparam logic [OFFSET_W-1:0]  OFFSET_MAX = 11'h7FF;
  localparam logic [DBAND_W-1:0]   DBAND_MAX  = 10'h3FF;

  // one expected report: status plus the held decoded values
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    decoded_t            vals;
  } rc_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [BYTE_W-1:0]     s_axis_tdata;
  logic [OP_W-1:0]       s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [TDATA_W-1:0]    m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  // decoder state as the testbench tracks it
  frame_t              stored_bytes;
  int unsigned         rx_count;
  decoded_t            held;
  logic [LIMIT_W-1:0]  miss_ticks;
  logic                link_lost;
  logic [OFFSET_W-1:0] cfg_offset;
  logic [DBAND_W-1:0]  cfg_dband;
  logic [LIMIT_W-1:0]  cfg_limit;

  rc_report_t  pending_reports[$];
  int          err_count = 0;
  int unsigned items_sent = 0;
  int          cycle_cnt = 0;
  bit          sender_idle_on = 1'b0;
  bit          receiver_idle_on = 1'b0;
  bit          hold_req = 1'b0;

  remote_control_frame_decoder_core u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // run length guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  // stick channel after offset subtraction and deadband
  function automatic logic [STICK_W-1:0] stick_after_deadband(logic [OFFSET_W-1:0] raw);
    int v;
    int w;
    v = int'(raw) - int'(cfg_offset);
    w = int'(cfg_dband);
    if (v > -w && v < w) begin
      v = 0;
    end
    return v[STICK_W-1:0];
  endfunction

  // advance the tracked decoder state by one input transaction
  task automatic update_rc_state(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data);
    rc_report_t rep;
    logic [6*BYTE_W-1:0] stick_bits;
    if (op == OP_NONE) begin
      return;
    end
    case (op)
      OP_BYTE: begin
        if (rx_count < FRAME_LEN) stored_bytes[rx_count] = data;
        if (rx_count < BUFFER_BYTES) rx_count++;
        rep.status = ST_STORED;
      end
      OP_IDLE: begin
        if (rx_count == FRAME_LEN) begin
          stick_bits = stored_bytes[5:0];
          held.stick0   = stick_after_deadband(stick_bits[10:0]);
          held.stick1   = stick_after_deadband(stick_bits[21:11]);
          held.stick2   = stick_after_deadband(stick_bits[32:22]);
          held.stick3   = stick_after_deadband(stick_bits[43:33]);
          held.switches = stick_bits[47:44];
          held.wheel    = stored_bytes[17:16] - WORD_W'(cfg_offset);
          held.mouse_x  = stored_bytes[7:6];
          held.mouse_y  = stored_bytes[9:8];
          held.mouse_z  = stored_bytes[11:10];
          held.buttons  = stored_bytes[13:12];
          held.keys     = stored_bytes[15:14];
          rep.status = ST_DECODED;
        end else begin
          rep.status = ST_REJECTED;
        end
        rx_count   = 0;
        miss_ticks = '0;
        link_lost  = 1'b0;
      end
      default: begin
        // heartbeat: saturate at the limit and flag the link as lost
        if (miss_ticks >= cfg_limit) begin
          miss_ticks = cfg_limit;
          link_lost  = 1'b1;
        end else begin
          miss_ticks++;
        end
        rep.status = link_lost ? ST_OFFLINE : ST_ALIVE;
      end
    endcase
    rep.vals = held;
    pending_reports.push_back(rep);
  endtask

  // one transaction on the input stream, with an occasional gap before it
  task automatic send_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data);
    if (sender_idle_on && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    update_rc_state(op, data);
    if (op != OP_NONE) items_sent++;
  endtask

  // register write, only while the decoder is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_OFFSET: cfg_offset = val[OFFSET_W-1:0];
      CFG_DBAND:  cfg_dband  = val[DBAND_W-1:0];
      CFG_LIMIT:  cfg_limit  = val[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // upper data bits carry junk that the decoder must drop
  task automatic set_config(logic [OFFSET_W-1:0] offset, logic [DBAND_W-1:0] dband,
                            logic [LIMIT_W-1:0] limit);
    write_reg(CFG_OFFSET, {5'($urandom), offset});
    write_reg(CFG_DBAND, {6'($urandom), dband});
    write_reg(CFG_LIMIT, limit);
  endtask

  // stop sending and wait for every report, plus the pipeline depth
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // raw stick value: extremes, around the deadband edges, or anything
  function automatic logic [OFFSET_W-1:0] pick_stick_raw();
    int v;
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = STICK_RAW_MAX;
      2, 3: v = int'(cfg_offset) + int'($urandom_range(0, 2 * cfg_dband + 4))
                - int'(cfg_dband) - 2;
      default: v = int'($urandom_range(0, STICK_RAW_MAX));
    endcase
    if (v < 0) v = 0;
    if (v > STICK_RAW_MAX) v = STICK_RAW_MAX;
    return v[OFFSET_W-1:0];
  endfunction

  function automatic frame_t make_frame(bit shaped);
    frame_t f;
    for (int i = 0; i < FRAME_LEN; i++) f[i] = 8'($urandom);
    if (shaped) begin
      f[5:0] = {4'($urandom), pick_stick_raw(), pick_stick_raw(), pick_stick_raw(),
                pick_stick_raw()};
    end
    return f;
  endfunction

  // a run of bytes closed by a line idle; bytes past the frame are random
  task automatic send_run(frame_t f, int unsigned len, bit with_ticks);
    for (int unsigned i = 0; i < len; i++) begin
      if (with_ticks && $urandom_range(0, 15) == 0) send_item(OP_TICK, 8'($urandom));
      send_item(OP_BYTE, (i < FRAME_LEN) ? f[i] : 8'($urandom));
    end
    send_item(OP_IDLE, 8'($urandom));
  endtask

  task automatic compare_field(string name, logic [WORD_W-1:0] exp, logic [WORD_W-1:0] act);
    if (act !== exp) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp, act);
      err_count++;
    end
  endtask

  // compare one output transaction with the oldest expectation
  task automatic check_report();
    rc_report_t want;
    decoded_t   got;
    got = m_axis_tdata[OUT_BITS-1:0];
    if (pending_reports.size() == 0) begin
      $display("%0t: unexpected report: expected none, actual status %h data %h",
               $time, m_axis_tuser, m_axis_tdata);
      err_count++;
    end else begin
      want = pending_reports.pop_front();
      compare_field("event_status", want.status, m_axis_tuser);
      compare_field("stick_ch0", want.vals.stick0, got.stick0);
      compare_field("stick_ch1", want.vals.stick1, got.stick1);
      compare_field("stick_ch2", want.vals.stick2, got.stick2);
      compare_field("stick_ch3", want.vals.stick3, got.stick3);
      compare_field("wheel_ch4", want.vals.wheel, got.wheel);
      compare_field("switch_pair", want.vals.switches, got.switches);
      compare_field("mouse_x", want.vals.mouse_x, got.mouse_x);
      compare_field("mouse_y", want.vals.mouse_y, got.mouse_y);
      compare_field("mouse_z", want.vals.mouse_z, got.mouse_z);
      compare_field("mouse_buttons", want.vals.buttons, got.buttons);
      compare_field("key_mask", want.vals.keys, got.keys);
      compare_field("zero fill", '0, m_axis_tdata[TDATA_W-1:OUT_BITS]);
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      check_report();
    end
  end

  // result receiver: random stalls, plus one long hold on request
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // every operation, both byte extremes, an empty and a full frame
  task automatic test_directed();
    frame_t f;
    write_reg(CFG_UNUSED, 16'($urandom));
    for (int i = 0; i < FRAME_LEN; i++) f[i] = (i % 2 == 0) ? 8'hFF : 8'h00;
    send_item(OP_NONE, 8'hFF);
    send_item(OP_TICK, 8'h00);
    send_item(OP_IDLE, 8'hFF);
    send_run(f, FRAME_LEN, 1'b0);
    send_item(OP_TICK, 8'h00);
  endtask

  // offline counter: zero limit, limit one, widest limit, limit lowered below count
  task automatic test_offline();
    wait_drain();
    write_reg(CFG_LIMIT, '0);
    send_item(OP_TICK, 8'($urandom));
    send_item(OP_TICK, 8'($urandom));
    send_item(OP_IDLE, 8'($urandom));
    send_item(OP_TICK, 8'($urandom));
    wait_drain();
    write_reg(CFG_LIMIT, 16'd1);
    send_item(OP_IDLE, 8'($urandom));
    repeat (3) send_item(OP_TICK, 8'($urandom));
    wait_drain();
    write_reg(CFG_LIMIT, LIMIT_MAX);
    send_item(OP_IDLE, 8'($urandom));
    repeat (10) send_item(OP_TICK, 8'($urandom));
    wait_drain();
    write_reg(CFG_LIMIT, 16'd4);
    repeat (2) send_item(OP_TICK, 8'($urandom));
    send_item(OP_IDLE, 8'($urandom));
    repeat (6) send_item(OP_TICK, 8'($urandom));
    wait_drain();
    write_reg(CFG_LIMIT, LIMIT_RST);
  endtask

  // stick offset and deadband at their extremes and in between
  task automatic test_stick_deadband();
    logic [OFFSET_W-1:0] offsets [4];
    logic [DBAND_W-1:0]  dbands [4];
    offsets = '{'0, OFFSET_MAX, OFFSET_RST, 11'($urandom)};
    dbands  = '{'0, DBAND_MAX, DBAND_RST, 10'($urandom_range(0, 200))};
    for (int s = 0; s < 4; s++) begin
      wait_drain();
      set_config(offsets[s], dbands[s], cfg_limit);
      repeat (3) send_run(make_frame(1'b1), FRAME_LEN, 1'b0);
    end
  endtask

  // short and overlong runs are rejected, then a good frame decodes cleanly
  task automatic test_overlong();
    int unsigned lens [10];
    lens = '{19, 20, 35, 36, 37, 45, 63, 17, 1, 0};
    foreach (lens[i]) send_run(make_frame(1'b1), lens[i], 1'b0);
    send_run(make_frame(1'b1), FRAME_LEN, 1'b0);
  endtask

  // receiver holds off while frames keep coming, then the sender waits it out
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (4) send_run(make_frame(1'b1), FRAME_LEN, 1'b1);
    wait_drain();
  endtask

  // mostly good frames with random content, the rest broken runs and noise
  task automatic test_random();
    int unsigned start;
    int unsigned goal;
    int          pick;
    start = items_sent;
    for (int phase = 0; phase < 3; phase++) begin
      goal = (start < ITEM_TARGET) ? start + (ITEM_TARGET - start) * (phase + 1) / 3
                                   : start + 100 * (phase + 1);
      wait_drain();
      set_config(11'($urandom),
                 (phase == 0) ? 10'($urandom_range(0, 60)) : 10'($urandom),
                 16'($urandom_range(0, 25)));
      while (items_sent < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_run(make_frame(1'($urandom)), FRAME_LEN, 1'b1);
        end else if (pick < 80) begin
          repeat ($urandom_range(1, 20)) send_item(OP_TICK, 8'($urandom));
        end else if (pick < 90) begin
          send_run(make_frame(1'b0), $urandom_range(0, 40), 1'b1);
        end else begin
          repeat ($urandom_range(1, 4)) send_item(2'($urandom), 8'($urandom));
        end
      end
    end
  endtask

  // back-to-back traffic with no stalls on either side
  task automatic test_quiet();
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    repeat (4) send_run(make_frame(1'b1), FRAME_LEN, 1'b1);
    repeat (5) send_item(OP_TICK, 8'($urandom));
  endtask

  // main sequence
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_BYTE;
    stored_bytes  = '0;
    rx_count      = 0;
    held          = '0;
    miss_ticks    = '0;
    link_lost     = 1'b0;
    cfg_offset    = OFFSET_RST;
    cfg_dband     = DBAND_RST;
    cfg_limit     = LIMIT_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    test_directed();
    test_offline();
    test_stick_deadband();
    test_overlong();
    test_backpressure();
    test_random();
    test_quiet();
    wait_drain();
    if (err_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/rcfd_pkg.sv
sv/rcfd_frame_buffer.sv
sv/rcfd_frame_unpack.sv
sv/rcfd_link_watch.sv
sv/remote_control_frame_decoder_core.sv
sv/rcfd_checker.sv
test/tb_top.sv
